FILE: rtl/flow_hash_counter_table_assert.svh
// Assertion macros for the flow table RTL, included by the top level
`ifndef FLOW_HASH_COUNTER_TABLE_ASSERT_SVH
`define FLOW_HASH_COUNTER_TABLE_ASSERT_SVH
`ifndef SYNTH
`define FHCT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
`define FHCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define FHCT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define FHCT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/fhct_pkg.sv
// Types, constants and helpers of the flow hash counter table
package fhct_pkg;

   localparam int BUCKETS_DEFAULT = 1024;
   localparam int WAYS_DEFAULT = 8;
   localparam logic [31:0] GOLDEN = 32'h9e3779b9;
   localparam int BIDX_W = 10;
   localparam int WIDX_W = 3;
   localparam int RCNT_W = 14;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
      logic [31:0] key_extra;
      logic [63:0] add_bytes;
      logic [63:0] add_packets;
   } req_type;

   typedef struct packed {
      logic              found;
      logic              inserted;
      logic              bucket_full;
      logic [BIDX_W-1:0] bucket_index;
      logic [WIDX_W-1:0] way_index;
      logic [63:0]       entry_bytes;
      logic [63:0]       entry_packets;
      logic [RCNT_W-1:0] record_count;
      logic [63:0]       total_bytes_out;
      logic [63:0]       total_packets_out;
   } rsp_type;

   typedef struct packed {
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
      logic [31:0] extra;
      logic [63:0] bytes;
      logic [63:0] packets;
   } entry_type;

   typedef struct packed {
      logic init_done;
   } back_stat_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MIX,
      F_MOD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_VWAIT,
      B_SCAN,
      B_ECMP,
      B_UPDATE,
      B_CLEAR,
      B_RESULT
   } back_state_type;

   function automatic logic [31:0] pack_word(input logic [63:0] high);
      return {high[47:40], high[55:48], high[63:56], high[39:32]};
   endfunction

endpackage

FILE: rtl/fhct_front.sv
// Front end: accept requests and compute the bucket by mix hash and remainder
module fhct_front #(
   parameter int BUCKETS = fhct_pkg::BUCKETS_DEFAULT,
   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fhct_pkg::back_stat_type back_stat,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fhct_pkg::req_type       req_payload,
   output logic                    job_valid,
   input  logic                    job_ready,
   output fhct_pkg::req_type       job_req,
   output logic [BKT_W-1:0]        job_bucket
);

   localparam int SHIFT = 32 + BKT_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam logic [32:0] RECIP = RECIP_WIDE[32:0];

   fhct_pkg::front_state_type state_ff, state_in;
   fhct_pkg::req_type req_ff, req_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [3:0] step_ff, step_in;
   logic [BKT_W-1:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [64:0] prod;
   logic [31:0] qd;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fhct_pkg::F_IDLE: if (req_valid && req_ready) state_in = fhct_pkg::F_MIX;
         fhct_pkg::F_MIX: if (step_ff == 4'd8) state_in = fhct_pkg::F_MOD;
         fhct_pkg::F_MOD: if (step_ff == 4'd1) state_in = fhct_pkg::F_PUSH;
         fhct_pkg::F_PUSH: if (job_ready) state_in = fhct_pkg::F_IDLE;
         default: state_in = fhct_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      prod = '0;
      qd = '0;
      unique case (state_ff)
         fhct_pkg::F_IDLE: begin
            req_in = req_payload;
            a_in = fhct_pkg::GOLDEN + fhct_pkg::pack_word(req_payload.dst_high);
            b_in = fhct_pkg::GOLDEN + fhct_pkg::pack_word(req_payload.src_high);
            c_in = '0;
            step_in = '0;
         end
         fhct_pkg::F_MIX: begin
            case (step_ff)
               4'd0: a_in = (a_ff - b_ff - c_ff) ^ (c_ff >> 13);
               4'd1: b_in = (b_ff - c_ff - a_ff) ^ (a_ff << 8);
               4'd2: c_in = (c_ff - a_ff - b_ff) ^ (b_ff >> 13);
               4'd3: a_in = (a_ff - b_ff - c_ff) ^ (c_ff >> 12);
               4'd4: b_in = (b_ff - c_ff - a_ff) ^ (a_ff << 16);
               4'd5: c_in = (c_ff - a_ff - b_ff) ^ (b_ff >> 5);
               4'd6: a_in = (a_ff - b_ff - c_ff) ^ (c_ff >> 3);
               4'd7: b_in = (b_ff - c_ff - a_ff) ^ (a_ff << 10);
               4'd8: c_in = (c_ff - a_ff - b_ff) ^ (b_ff >> 15);
               default: c_in = c_ff;
            endcase
            step_in = (step_ff == 4'd8) ? 4'd0 : step_ff + 4'd1;
            rem_in = '0;
         end
         fhct_pkg::F_MOD: begin
            if (step_ff == 4'd0) begin
               prod = 65'(c_ff) * 65'(RECIP);
               quot_in = 32'(prod >> SHIFT);
            end else begin
               qd = quot_ff * 32'(BUCKETS);
               rem_in = BKT_W'(c_ff - qd);
            end
            step_in = (step_ff == 4'd1) ? 4'd0 : step_ff + 4'd1;
         end
         fhct_pkg::F_PUSH: step_in = '0;
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fhct_pkg::F_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
      req_ff <= req_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
   end

   assign req_ready = (state_ff == fhct_pkg::F_IDLE) && back_stat.init_done;
   assign job_valid = (state_ff == fhct_pkg::F_PUSH);
   assign job_req = req_ff;
   assign job_bucket = rem_ff;

endmodule

FILE: rtl/fhct_queue.sv
// Two-entry queue between front and back
module fhct_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/fhct_back.sv
// Back end: init and clear sweeps, bucket scan, entry update, counters and result register
module fhct_back #(
   parameter int BUCKETS = fhct_pkg::BUCKETS_DEFAULT,
   parameter int WAYS = fhct_pkg::WAYS_DEFAULT,
   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  fhct_pkg::req_type       job_req,
   input  logic [BKT_W-1:0]        job_bucket,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fhct_pkg::rsp_type       rsp_payload,
   output fhct_pkg::back_stat_type back_stat
);

   localparam int SLOTS = BUCKETS * WAYS;
   localparam int EA_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WI_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WC_W = $clog2(WAYS + 1);
   localparam int RC_W = $clog2(SLOTS + 1);

   fhct_pkg::back_state_type state_ff, state_in;
   fhct_pkg::req_type req_ff, req_in;
   fhct_pkg::rsp_type res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [BKT_W-1:0] bucket_ff, bucket_in, sweep_ff, sweep_in;
   logic [WAYS-1:0] row_ff, row_in;
   logic [WI_W-1:0] free_ff, free_in;
   logic has_free_ff, has_free_in;
   logic [EA_W-1:0] base_ff, base_in;
   logic [WC_W-1:0] way_ff, way_in;
   logic hit_ff, hit_in;
   logic [RC_W-1:0] count_ff, count_in;
   logic [63:0] sum_bytes_ff, sum_bytes_in, sum_pkts_ff, sum_pkts_in;

   logic [WAYS-1:0] vmem [BUCKETS];
   logic [WAYS-1:0] vmem_rd_ff;
   fhct_pkg::entry_type emem [SLOTS];
   fhct_pkg::entry_type emem_rd_ff;

   logic v_ren, v_wen;
   logic [BKT_W-1:0] v_raddr, v_waddr;
   logic [WAYS-1:0] v_wdata;
   logic e_ren, e_wen;
   logic [EA_W-1:0] e_raddr, e_waddr;
   fhct_pkg::entry_type e_wdata;

   logic [WI_W-1:0] way_idx;
   logic sweep_last, out_free, key_match;
   logic [EA_W-1:0] way_addr;

   assign way_idx = way_ff[WI_W-1:0];
   assign sweep_last = (sweep_ff == BKT_W'(BUCKETS - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign way_addr = base_ff + EA_W'(way_ff);
   assign key_match = (emem_rd_ff.src_high == req_ff.src_high)
                      && (emem_rd_ff.src_low == req_ff.src_low)
                      && (emem_rd_ff.dst_high == req_ff.dst_high)
                      && (emem_rd_ff.dst_low == req_ff.dst_low)
                      && (emem_rd_ff.extra == req_ff.key_extra);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fhct_pkg::B_INIT: if (sweep_last) state_in = fhct_pkg::B_IDLE;
         fhct_pkg::B_IDLE: begin
            if (job_valid) begin
               unique case (job_req.opcode)
                  fhct_pkg::OP_CLEAR: state_in = fhct_pkg::B_CLEAR;
                  fhct_pkg::OP_NONE: state_in = fhct_pkg::B_RESULT;
                  default: state_in = fhct_pkg::B_VWAIT;
               endcase
            end
         end
         fhct_pkg::B_VWAIT: state_in = fhct_pkg::B_SCAN;
         fhct_pkg::B_SCAN: begin
            if (way_ff == WC_W'(WAYS)) state_in = fhct_pkg::B_UPDATE;
            else if (row_ff[way_idx]) state_in = fhct_pkg::B_ECMP;
         end
         fhct_pkg::B_ECMP: state_in = key_match ? fhct_pkg::B_UPDATE : fhct_pkg::B_SCAN;
         fhct_pkg::B_UPDATE: state_in = fhct_pkg::B_RESULT;
         fhct_pkg::B_CLEAR: if (sweep_last) state_in = fhct_pkg::B_RESULT;
         fhct_pkg::B_RESULT: if (out_free) state_in = fhct_pkg::B_IDLE;
         default: state_in = fhct_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      res_in = res_ff;
      bucket_in = bucket_ff;
      sweep_in = sweep_ff;
      row_in = row_ff;
      free_in = free_ff;
      has_free_in = has_free_ff;
      base_in = base_ff;
      way_in = way_ff;
      hit_in = hit_ff;
      count_in = count_ff;
      sum_bytes_in = sum_bytes_ff;
      sum_pkts_in = sum_pkts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      v_ren = 1'b0;
      v_raddr = job_bucket;
      v_wen = 1'b0;
      v_waddr = sweep_ff;
      v_wdata = '0;
      e_ren = 1'b0;
      e_raddr = way_addr;
      e_wen = 1'b0;
      e_waddr = way_addr;
      e_wdata = emem_rd_ff;
      unique case (state_ff)
         fhct_pkg::B_INIT, fhct_pkg::B_CLEAR: begin
            v_wen = 1'b1;
            sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
         end
         fhct_pkg::B_IDLE: begin
            req_in = job_req;
            bucket_in = job_bucket;
            v_ren = job_valid;
            sweep_in = '0;
            hit_in = 1'b0;
            res_in = '0;
            if (job_req.opcode == fhct_pkg::OP_CLEAR) begin
               if (job_valid) begin
                  count_in = '0;
                  sum_bytes_in = '0;
                  sum_pkts_in = '0;
               end
            end else begin
               res_in.bucket_index = fhct_pkg::BIDX_W'(job_bucket);
               res_in.record_count = fhct_pkg::RCNT_W'(count_ff);
               res_in.total_bytes_out = sum_bytes_ff;
               res_in.total_packets_out = sum_pkts_ff;
            end
         end
         fhct_pkg::B_VWAIT: begin
            row_in = vmem_rd_ff;
            has_free_in = 1'b0;
            free_in = '0;
            for (int k = WAYS - 1; k >= 0; k--) begin
               if (!vmem_rd_ff[k]) begin
                  free_in = WI_W'(k);
                  has_free_in = 1'b1;
               end
            end
            base_in = EA_W'(bucket_ff) * EA_W'(WAYS);
            way_in = '0;
         end
         fhct_pkg::B_SCAN: begin
            if (way_ff != WC_W'(WAYS)) begin
               if (row_ff[way_idx]) e_ren = 1'b1;
               else way_in = way_ff + 1'b1;
            end
         end
         fhct_pkg::B_ECMP: begin
            if (key_match) hit_in = 1'b1;
            else way_in = way_ff + 1'b1;
         end
         fhct_pkg::B_UPDATE: begin
            if (hit_ff) begin
               res_in.found = 1'b1;
               res_in.way_index = fhct_pkg::WIDX_W'(way_ff);
               res_in.entry_bytes = emem_rd_ff.bytes;
               res_in.entry_packets = emem_rd_ff.packets;
               if (req_ff.opcode == fhct_pkg::OP_ADD) begin
                  e_wen = 1'b1;
                  e_wdata.bytes = emem_rd_ff.bytes + req_ff.add_bytes;
                  e_wdata.packets = emem_rd_ff.packets + req_ff.add_packets;
                  sum_bytes_in = sum_bytes_ff + req_ff.add_bytes;
                  sum_pkts_in = sum_pkts_ff + req_ff.add_packets;
                  res_in.entry_bytes = e_wdata.bytes;
                  res_in.entry_packets = e_wdata.packets;
               end
            end else if (has_free_ff) begin
               e_wen = 1'b1;
               e_waddr = base_ff + EA_W'(free_ff);
               e_wdata.src_high = req_ff.src_high;
               e_wdata.src_low = req_ff.src_low;
               e_wdata.dst_high = req_ff.dst_high;
               e_wdata.dst_low = req_ff.dst_low;
               e_wdata.extra = req_ff.key_extra;
               e_wdata.bytes = '0;
               e_wdata.packets = '0;
               v_wen = 1'b1;
               v_waddr = bucket_ff;
               v_wdata = row_ff | (WAYS'(1) << free_ff);
               count_in = count_ff + 1'b1;
               if (req_ff.opcode == fhct_pkg::OP_ADD) begin
                  e_wdata.bytes = req_ff.add_bytes;
                  e_wdata.packets = req_ff.add_packets;
                  sum_bytes_in = sum_bytes_ff + req_ff.add_bytes;
                  sum_pkts_in = sum_pkts_ff + req_ff.add_packets;
               end
               res_in.inserted = 1'b1;
               res_in.way_index = fhct_pkg::WIDX_W'(free_ff);
               res_in.entry_bytes = e_wdata.bytes;
               res_in.entry_packets = e_wdata.packets;
            end else begin
               res_in.bucket_full = 1'b1;
            end
            res_in.record_count = fhct_pkg::RCNT_W'(count_in);
            res_in.total_bytes_out = sum_bytes_in;
            res_in.total_packets_out = sum_pkts_in;
         end
         fhct_pkg::B_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
            end
         end
         default: hit_in = hit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fhct_pkg::B_INIT;
         sweep_ff <= '0;
         count_ff <= '0;
         sum_bytes_ff <= '0;
         sum_pkts_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         count_ff <= count_in;
         sum_bytes_ff <= sum_bytes_in;
         sum_pkts_ff <= sum_pkts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
      bucket_ff <= bucket_in;
      row_ff <= row_in;
      free_ff <= free_in;
      has_free_ff <= has_free_in;
      base_ff <= base_in;
      way_ff <= way_in;
      hit_ff <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (v_wen) vmem[v_waddr] <= v_wdata;
      if (v_ren) vmem_rd_ff <= vmem[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (e_wen) emem[e_waddr] <= e_wdata;
      if (e_ren) emem_rd_ff <= emem[e_raddr];
   end

   assign job_ready = (state_ff == fhct_pkg::B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign back_stat.init_done = (state_ff != fhct_pkg::B_INIT);

endmodule

FILE: rtl/flow_hash_counter_table.sv
// Flow hash counter table top level
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_payload (fhct_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_ready  rsp_payload (fhct_pkg::rsp_type)
//
// Front: accept, the mix rounds, the remainder (reciprocal multiply, then subtract), then a push to the queue.
// Back: reads the bucket's valid bits, scans the ways and compares the key of each valid way, then
// updates the matching entry or inserts into a free way, and posts the result.
// Clear runs a sweep over every bucket of the valid-bit memory.
// After reset the same sweep runs; req_ready stays low until it is done.
// A result waits in the output register while the front takes the next request.
module flow_hash_counter_table #(
   parameter int BUCKETS = fhct_pkg::BUCKETS_DEFAULT,
   parameter int WAYS = fhct_pkg::WAYS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fhct_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fhct_pkg::rsp_type rsp_payload
);

   `include "flow_hash_counter_table_assert.svh"

   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int JOB_W = $bits(fhct_pkg::req_type) + BKT_W;

   fhct_pkg::back_stat_type back_stat;
   logic f_valid, f_ready, b_valid, b_ready;
   fhct_pkg::req_type f_req, b_req;
   logic [BKT_W-1:0] f_bucket, b_bucket;
   logic [JOB_W-1:0] b_data;
   logic [2:0] rsp_flags;

   fhct_front #(.BUCKETS(BUCKETS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .back_stat   (back_stat),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_valid   (f_valid),
      .job_ready   (f_ready),
      .job_req     (f_req),
      .job_bucket  (f_bucket)
   );

   fhct_queue #(.DATA_W(JOB_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_req, f_bucket}),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   assign b_req = b_data[JOB_W-1:BKT_W];
   assign b_bucket = b_data[BKT_W-1:0];

   fhct_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (b_valid),
      .job_ready   (b_ready),
      .job_req     (b_req),
      .job_bucket  (b_bucket),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .back_stat   (back_stat)
   );

   assign rsp_flags = {rsp_payload.found, rsp_payload.inserted, rsp_payload.bucket_full};

   `FHCT_ASSERT_IMPLY(a_no_accept_in_init, clock, reset, !back_stat.init_done, !req_ready)
   `FHCT_ASSERT_IMPLY(a_flags_exclusive, clock, reset, rsp_valid, $onehot0(rsp_flags))
   `FHCT_ASSERT_NEXT(a_back_busy_after_pop, clock, reset, b_valid && b_ready, !b_ready)

endmodule
